@@ rtl/bafk_pkg.sv @@
// ----------------------------------------------------------------------------
// bafk_pkg
// Shared types for the range-flip / k-th-one bit array.
// ----------------------------------------------------------------------------
package bafk_pkg;

  localparam int unsigned FIELD_W = 10;
  localparam int unsigned CFG_W   = 11;

  localparam logic CMD_FLIP = 1'b0;
  localparam logic CMD_KTH  = 1'b1;

  typedef struct packed {
    logic               command;
    logic [FIELD_W-1:0] range_first;
    logic [FIELD_W-1:0] range_last;
    logic [FIELD_W-1:0] rank;
  } in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] position;
    logic               found;
  } out_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_F_VISIT,
    ST_F_COVER,
    ST_F_PD,
    ST_F_PDL,
    ST_F_PDR,
    ST_F_RET,
    ST_F_SUM1,
    ST_F_SUM2,
    ST_Q_CHK,
    ST_Q_NODE,
    ST_Q_PD,
    ST_Q_PDL,
    ST_Q_PDR,
    ST_Q_CLR,
    ST_Q_DEC
  } state_t;

endpackage

@@ rtl/bafk_ram.sv @@
// ----------------------------------------------------------------------------
// bafk_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module bafk_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/bit_array_range_flip_kth_one_unit.sv @@
// ----------------------------------------------------------------------------
// bit_array_range_flip_kth_one_unit
// Bit array kept as a lazy segment tree of one-counts in a single RAM.
//
// Input: a command beat is taken when start is high and busy is low.
//   command 0 inverts bits range_first..range_last (no result);
//   command 1 returns the position of the rank-th one bit.
// Output: out_valid strobes for one cycle with out_data; the receiver
//   cannot stall, so results are never held.
// Config: cfg_data (element_count) is taken whenever cfg_valid is high;
//   cfg_ready is always high. A write saturates to 1..MAX_ELEMENTS and
//   clears the array.
// Operation: one command at a time. A flip leaves a disjoint node alone,
//   inverts a fully covered one and toggles its pending flag, and on a
//   partly covered one pushes a pending flip down to both children first;
//   child sums are written back on the way up. A rank beyond the count of
//   ones gives found=0; else each level of a query pushes down, reads the
//   left child and descends. The result strobes in the cycle after it is decided.
// Reset and every config write start a clearing pass over all
//   4*MAX_ELEMENTS RAM words; busy stays high during it.
// ----------------------------------------------------------------------------
module bit_array_range_flip_kth_one_unit #(
  parameter int unsigned MAX_ELEMENTS = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  bafk_pkg::in_t                   in_data,
  output logic                            out_valid,
  output bafk_pkg::out_t                  out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bafk_pkg::CFG_W-1:0]      cfg_data
);

  import bafk_pkg::*;

  localparam int unsigned DEPTH = 4 * MAX_ELEMENTS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned IW    = $clog2(MAX_ELEMENTS);
  localparam int unsigned PW    = (IW > FIELD_W) ? IW : FIELD_W;
  localparam int unsigned W     = PW + 1;
  localparam int unsigned CNTW  = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned SD    = IW + 1;
  localparam int unsigned SIW   = $clog2(SD);
  localparam int unsigned RST_N = (MAX_ELEMENTS < 1024) ? MAX_ELEMENTS : 1024;

  state_t state_r, state_nxt;
  logic [AW-1:0]   v_r, v_nxt;
  logic [PW-1:0]   lo_r, lo_nxt, hi_r, hi_nxt;
  logic [SIW:0]    depth_r, depth_nxt;
  logic [PW-1:0]   flo_r, flo_nxt, fhi_r, fhi_nxt;
  logic [W-1:0]    k_r, k_nxt;
  logic [CNTW-1:0] cv_r, cv_nxt, tmp_r, tmp_nxt;
  logic [CNTW-1:0] ec_r;
  logic [AW-1:0]   clr_r, clr_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_t            out_r, out_nxt;
  logic [PW-1:0]   stk_lo_r [SD];
  logic [PW-1:0]   stk_hi_r [SD];

  logic            push_en;
  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [CNTW:0]   wdata, rdata;
  logic            r_pend;
  logic [CNTW-1:0] r_cnt;
  logic [PW-1:0]   mid;
  logic [W-1:0]    size_v, size_l, size_r;
  logic [AW-1:0]   v2, v2p1;
  logic [SIW:0]    dm1;
  logic [PW-1:0]   p_lo, p_hi, p_mid;
  logic [CNTW-1:0] cfg_n;

  bafk_ram #(.WIDTH(CNTW + 1), .DEPTH(DEPTH)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign r_pend = rdata[CNTW];
  assign r_cnt  = rdata[CNTW-1:0];
  assign mid    = PW'((W'(lo_r) + W'(hi_r)) >> 1);
  assign size_v = W'(hi_r) - W'(lo_r) + W'(1);
  assign size_l = W'(mid) - W'(lo_r) + W'(1);
  assign size_r = W'(hi_r) - W'(mid);
  assign v2     = {v_r[AW-2:0], 1'b0};
  assign v2p1   = {v_r[AW-2:0], 1'b1};
  assign dm1    = depth_r - 1'b1;
  assign p_lo   = stk_lo_r[dm1[SIW-1:0]];
  assign p_hi   = stk_hi_r[dm1[SIW-1:0]];
  assign p_mid  = PW'((W'(p_lo) + W'(p_hi)) >> 1);

  always_comb begin
    if (cfg_data == '0) begin
      cfg_n = CNTW'(1);
    end else if (32'(cfg_data) > 32'(MAX_ELEMENTS)) begin
      cfg_n = CNTW'(MAX_ELEMENTS);
    end else begin
      cfg_n = CNTW'(cfg_data);
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    v_nxt         = v_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    depth_nxt     = depth_r;
    flo_nxt       = flo_r;
    fhi_nxt       = fhi_r;
    k_nxt         = k_r;
    cv_nxt        = cv_r;
    tmp_nxt       = tmp_r;
    clr_nxt       = clr_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    push_en       = 1'b0;
    we            = 1'b0;
    waddr         = v_r;
    wdata         = '0;
    raddr         = v_r;
    unique case (state_r)
      ST_CLEAR: begin
        we      = 1'b1;
        waddr   = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        v_nxt     = AW'(1);
        lo_nxt    = '0;
        hi_nxt    = PW'(ec_r - 1'b1);
        depth_nxt = '0;
        raddr     = AW'(1);
        if (start) begin
          if (in_data.command == CMD_FLIP) begin
            flo_nxt = PW'(in_data.range_first);
            fhi_nxt = PW'(in_data.range_last);
            if (in_data.range_first <= in_data.range_last) begin
              state_nxt = ST_F_VISIT;
            end
          end else begin
            k_nxt     = W'(in_data.rank);
            state_nxt = ST_Q_CHK;
          end
        end
      end
      ST_F_VISIT: begin
        if (lo_r > fhi_r || hi_r < flo_r) begin
          state_nxt = ST_F_RET;
        end else if (flo_r <= lo_r && hi_r <= fhi_r) begin
          state_nxt = ST_F_COVER;
        end else begin
          state_nxt = ST_F_PD;
        end
      end
      ST_F_COVER: begin
        we        = 1'b1;
        wdata     = {~r_pend, CNTW'(size_v - W'(r_cnt))};
        state_nxt = ST_F_RET;
      end
      ST_F_PD: begin
        if (r_pend) begin
          raddr     = v2;
          state_nxt = ST_F_PDL;
        end else begin
          push_en   = 1'b1;
          depth_nxt = depth_r + 1'b1;
          v_nxt     = v2;
          hi_nxt    = mid;
          state_nxt = ST_F_VISIT;
        end
      end
      ST_F_PDL: begin
        we        = 1'b1;
        waddr     = v2;
        wdata     = {~r_pend, CNTW'(size_l - W'(r_cnt))};
        raddr     = v2p1;
        state_nxt = ST_F_PDR;
      end
      ST_F_PDR: begin
        we        = 1'b1;
        waddr     = v2p1;
        wdata     = {~r_pend, CNTW'(size_r - W'(r_cnt))};
        push_en   = 1'b1;
        depth_nxt = depth_r + 1'b1;
        v_nxt     = v2;
        hi_nxt    = mid;
        state_nxt = ST_F_VISIT;
      end
      ST_F_RET: begin
        if (depth_r == '0) begin
          state_nxt = ST_IDLE;
        end else if (!v_r[0]) begin
          v_nxt     = v_r + 1'b1;
          lo_nxt    = p_mid + 1'b1;
          hi_nxt    = p_hi;
          state_nxt = ST_F_VISIT;
        end else begin
          raddr     = v_r - 1'b1;
          depth_nxt = dm1;
          v_nxt     = v_r >> 1;
          lo_nxt    = p_lo;
          hi_nxt    = p_hi;
          state_nxt = ST_F_SUM1;
        end
      end
      ST_F_SUM1: begin
        tmp_nxt   = r_cnt;
        raddr     = v2p1;
        state_nxt = ST_F_SUM2;
      end
      ST_F_SUM2: begin
        we        = 1'b1;
        wdata     = {1'b0, tmp_r + r_cnt};
        state_nxt = ST_F_RET;
      end
      ST_Q_CHK: begin
        if (k_r >= W'(r_cnt)) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{position: '0, found: 1'b0};
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_Q_NODE;
        end
      end
      ST_Q_NODE: begin
        if (lo_r == hi_r) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{position: lo_r[FIELD_W-1:0], found: 1'b1};
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_Q_PD;
        end
      end
      ST_Q_PD: begin
        cv_nxt = r_cnt;
        raddr  = v2;
        if (r_pend) begin
          state_nxt = ST_Q_PDL;
        end else begin
          state_nxt = ST_Q_DEC;
        end
      end
      ST_Q_PDL: begin
        we        = 1'b1;
        waddr     = v2;
        wdata     = {~r_pend, CNTW'(size_l - W'(r_cnt))};
        tmp_nxt   = CNTW'(size_l - W'(r_cnt));
        raddr     = v2p1;
        state_nxt = ST_Q_PDR;
      end
      ST_Q_PDR: begin
        we        = 1'b1;
        waddr     = v2p1;
        wdata     = {~r_pend, CNTW'(size_r - W'(r_cnt))};
        state_nxt = ST_Q_CLR;
      end
      ST_Q_CLR, ST_Q_DEC: begin
        if (state_r == ST_Q_CLR) begin
          we    = 1'b1;
          wdata = {1'b0, cv_r};
        end else begin
          tmp_nxt = r_cnt;
        end
        state_nxt = ST_Q_NODE;
        if (k_r < W'((state_r == ST_Q_CLR) ? tmp_r : r_cnt)) begin
          v_nxt  = v2;
          hi_nxt = mid;
        end else begin
          k_nxt  = k_r - W'((state_r == ST_Q_CLR) ? tmp_r : r_cnt);
          v_nxt  = v2p1;
          lo_nxt = mid + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (cfg_valid) begin
      state_nxt = ST_CLEAR;
      clr_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      ec_r        <= CNTW'(RST_N);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        ec_r <= cfg_n;
      end
    end
  end

  always_ff @(posedge clk) begin
    v_r     <= v_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    depth_r <= depth_nxt;
    flo_r   <= flo_nxt;
    fhi_r   <= fhi_nxt;
    k_r     <= k_nxt;
    cv_r    <= cv_nxt;
    tmp_r   <= tmp_nxt;
    out_r   <= out_nxt;
    if (push_en) begin
      stk_lo_r[depth_r[SIW-1:0]] <= lo_r;
      stk_hi_r[depth_r[SIW-1:0]] <= hi_r;
    end
  end

endmodule
